### rtl/bpc_pkg.sv
// Package for the button press classifier: event codes, counter sizing,
// register map and the configuration struct. No dependencies.
`default_nettype none

package bpc_pkg;

  // Press and gap counters; held_ticks reports at most 16 bits of them.
  localparam int COUNT_WIDTH = 16;
  localparam int HELD_WIDTH  = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > HELD_WIDTH) ? COUNT_WIDTH : HELD_WIDTH;

  localparam int DEBOUNCE_WIDTH = 4;
  localparam int EVENT_WIDTH    = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_WIDTH  = 8;
  localparam int OUT_DATA_WIDTH = 24;

  // APB register map.
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int CFG_DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    REG_INVERT       = 2'd0,
    REG_LONG_TICKS   = 2'd1,
    REG_DOUBLE_TICKS = 2'd2,
    REG_DEBOUNCE     = 2'd3
  } reg_idx_t;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_LONG     = 3'd3,
    EV_DOUBLE   = 3'd4
  } event_t;

  typedef struct packed {
    logic                      invert_pin;
    logic [HELD_WIDTH-1:0]     long_ticks;
    logic [HELD_WIDTH-1:0]     double_ticks;
    logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [HELD_WIDTH-1:0] held_ticks;
    logic                  held_now;
    event_t                event_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/bpc_cfg_regs.sv
// APB configuration registers of the button press classifier.
// Depends on bpc_pkg for the register map and the configuration struct.
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bpc_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  wire logic [bpc_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic      [bpc_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                     pready,
  output bpc_pkg::cfg_t                            cfg
);
  import bpc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_INVERT:       cfg_nxt.invert_pin     = pwdata[0];
        REG_LONG_TICKS:   cfg_nxt.long_ticks     = pwdata[HELD_WIDTH-1:0];
        REG_DOUBLE_TICKS: cfg_nxt.double_ticks   = pwdata[HELD_WIDTH-1:0];
        REG_DEBOUNCE:     cfg_nxt.debounce_ticks = pwdata[DEBOUNCE_WIDTH-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_pin     <= 1'b1;
      cfg_r.long_ticks     <= HELD_WIDTH'(100);
      cfg_r.double_ticks   <= HELD_WIDTH'(30);
      cfg_r.debounce_ticks <= DEBOUNCE_WIDTH'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (idx)
      REG_INVERT:       prdata = CFG_DATA_WIDTH'(cfg_r.invert_pin);
      REG_LONG_TICKS:   prdata = CFG_DATA_WIDTH'(cfg_r.long_ticks);
      REG_DOUBLE_TICKS: prdata = CFG_DATA_WIDTH'(cfg_r.double_ticks);
      REG_DEBOUNCE:     prdata = CFG_DATA_WIDTH'(cfg_r.debounce_ticks);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/bpc_core.sv
// Debounce and classification state of the button press classifier.
// Depends on bpc_pkg; updates its state once for each sample it is told to take.
`default_nettype none

module bpc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             pin_level,
  input  wire bpc_pkg::cfg_t    cfg,
  output bpc_pkg::result_t      result
);
  import bpc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                      last_level_r,   last_level_nxt;
  logic                      pressed_r,      pressed_nxt;
  logic [DEBOUNCE_WIDTH-1:0] settle_r,       settle_nxt;
  logic [COUNT_WIDTH-1:0]    press_cnt_r,    press_cnt_nxt;
  logic [COUNT_WIDTH-1:0]    gap_cnt_r,      gap_cnt_nxt;
  logic                      first_short_r,  first_short_nxt;

  logic                      lvl;
  logic                      have;
  logic [COUNT_WIDTH-1:0]    press_adv;
  logic [COUNT_WIDTH-1:0]    gap_adv;
  logic [DEBOUNCE_WIDTH-1:0] settle_dec;
  logic                      is_long;
  logic                      in_window;
  logic [CMP_WIDTH-1:0]      held_wide;
  event_t                    ev;

  assign lvl = pin_level ^ cfg.invert_pin;

  // Counters advance first and stop at their maximum.
  assign press_adv = (pressed_r && press_cnt_r != CNT_MAX) ? press_cnt_r + 1'b1 : press_cnt_r;
  assign gap_adv   = (first_short_r && gap_cnt_r != CNT_MAX) ? gap_cnt_r + 1'b1 : gap_cnt_r;

  assign settle_dec = settle_r - 1'b1;

  // A saturated press always counts as long; a saturated gap never counts as short.
  assign is_long   = (CMP_WIDTH'(press_adv) >= CMP_WIDTH'(cfg.long_ticks)) ||
                     (press_adv == CNT_MAX);
  assign in_window = first_short_r && (CMP_WIDTH'(gap_adv) < CMP_WIDTH'(cfg.double_ticks)) &&
                     (gap_adv != CNT_MAX);

  // Debounce: decide whether this sample becomes the reading.
  always_comb begin
    settle_nxt = settle_r;
    have       = 1'b0;
    if (settle_r != '0) begin
      settle_nxt = settle_dec;
      have       = (settle_dec == '0);
    end else if (lvl != last_level_r) begin
      if (cfg.debounce_ticks == '0) begin
        have = 1'b1;
      end else begin
        settle_nxt = cfg.debounce_ticks;
      end
    end else begin
      have = 1'b1;
    end
  end

  // Classify edges of the debounced reading.
  always_comb begin
    last_level_nxt  = have ? lvl : last_level_r;
    pressed_nxt     = pressed_r;
    press_cnt_nxt   = press_adv;
    gap_cnt_nxt     = gap_adv;
    first_short_nxt = first_short_r;
    ev              = EV_NONE;
    if (have && lvl && !pressed_r) begin
      pressed_nxt   = 1'b1;
      press_cnt_nxt = '0;
      ev            = EV_PRESSED;
    end else if (have && !lvl && pressed_r) begin
      pressed_nxt = 1'b0;
      if (is_long) begin
        ev = EV_LONG;
      end else if (in_window) begin
        ev              = EV_DOUBLE;
        first_short_nxt = 1'b0;
      end else begin
        ev              = EV_RELEASED;
        first_short_nxt = 1'b1;
        gap_cnt_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b0;
      pressed_r     <= 1'b0;
      settle_r      <= '0;
      press_cnt_r   <= '0;
      gap_cnt_r     <= '0;
      first_short_r <= 1'b0;
    end else if (step) begin
      last_level_r  <= last_level_nxt;
      pressed_r     <= pressed_nxt;
      settle_r      <= settle_nxt;
      press_cnt_r   <= press_cnt_nxt;
      gap_cnt_r     <= gap_cnt_nxt;
      first_short_r <= first_short_nxt;
    end
  end

  // Held time reported while pressed, clipped to the output field.
  assign held_wide = pressed_nxt ? CMP_WIDTH'(press_cnt_nxt) : '0;

  always_comb begin
    result.event_code = ev;
    result.held_now   = pressed_nxt;
    if (held_wide > CMP_WIDTH'({HELD_WIDTH{1'b1}})) begin
      result.held_ticks = '1;
    end else begin
      result.held_ticks = held_wide[HELD_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/button_press_classifier.sv
// Button press classifier: one raw pin sample in, one event result out per request.
// Each input request is held in an input register, classified combinationally and
// placed in the output register, so a sample can be accepted on every clock while the
// output side is ready. The input register frees up while a result waits, so one
// further sample is taken during an output stall. Throughput is one sample per cycle
// while the output side is ready; the debounce and press/gap counters update once per
// sample. Thresholds are in samples. The user must write configuration over the APB
// port only while no request is open; the block itself does not enforce this.
`default_nettype none

module button_press_classifier (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [bpc_pkg::IN_DATA_WIDTH-1:0]   in_tdata,   // [0] pin_level
  // Result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [bpc_pkg::OUT_DATA_WIDTH-1:0]  out_tdata,  // [2:0] event_code,
                                                               // [3] held_now,
                                                               // [19:4] held_ticks
  // Configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [bpc_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  wire logic [bpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_pwdata,
  output logic      [bpc_pkg::CFG_DATA_WIDTH-1:0]  cfg_prdata,
  output logic                                     cfg_pready
);
  import bpc_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic    in_valid_r, in_valid_nxt;
  logic    pin_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;
  logic    advance;

  bpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // A held sample moves on when the output register is free or being drained.
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  bpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .pin_level (pin_r),
    .cfg       (cfg),
    .result    (result)
  );

  // Handshake state for both register stages.
  always_comb begin
    in_valid_nxt  = (in_tvalid & in_tready) | (in_valid_r & ~advance);
    out_valid_nxt = advance | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pin_r <= in_tdata[0];
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_WIDTH'(out_data_r);

endmodule

`default_nettype wire

### rtl/bpc_checker.sv
// Port-level checks for the button press classifier, bound to its top level.
// Depends on bpc_pkg for event codes and payload widths.
`default_nettype none

module bpc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [bpc_pkg::OUT_DATA_WIDTH-1:0]  out_tdata
);
  import bpc_pkg::*;

  logic [EVENT_WIDTH-1:0] ev;
  logic                   held_now;
  logic [HELD_WIDTH-1:0]  held_ticks;

  assign ev         = out_tdata[EVENT_WIDTH-1:0];
  assign held_now   = out_tdata[EVENT_WIDTH];
  assign held_ticks = out_tdata[EVENT_WIDTH+HELD_WIDTH:EVENT_WIDTH+1];

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A released button reports no held time and no padding bits.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !held_now |-> out_tdata[OUT_DATA_WIDTH-1:EVENT_WIDTH+1] == '0)
    else $error("held time reported while released");

  // A press starts the count at zero with the button held.
  a_press_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ev == EV_PRESSED |-> held_now && held_ticks == '0)
    else $error("press event without a fresh hold");

  // Every release kind leaves the button released.
  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ev == EV_RELEASED || ev == EV_LONG || ev == EV_DOUBLE) |-> !held_now)
    else $error("release event while still held");

  // After reset the input side is free to take a sample, or a sample is offered.
  a_ready_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> in_tready || in_tvalid)
    else $error("input not ready after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
